@@ hdl/lis_pkg.sv @@
// ----------------------------------------------------------------------------
// LIS package
// Shared types and constants for the longest increasing subsequence core.
// ----------------------------------------------------------------------------
package lis_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int DATA_W    = 32;

    typedef logic signed [DATA_W-1:0] sample_t;
    typedef logic [IDX_W-1:0]          idx_t;
    typedef logic [CNT_W-1:0]          cnt_t;

    typedef struct packed {
        sample_t sample;
        logic    final_item;
    } in_item_t;

    typedef struct packed {
        sample_t element;
        logic    run_end;
        logic    dropped;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH,
        ST_SWAIT,
        ST_SCMP,
        ST_CHK,
        ST_CWAIT,
        ST_UPD,
        ST_TSTART,
        ST_TWAIT,
        ST_TSTEP,
        ST_EMIT,
        ST_EWAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic store_in;
        logic srch_rd;
        logic srch_cmp;
        logic chk_rd;
        logic upd;
        logic seq_clr;
        logic trace_init;
        logic trace_rd;
        logic trace_step;
        logic emit_init;
        logic emit_rd;
        logic emit_load;
        logic emit_adv;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic srch_done;
        logic trace_done;
        logic trace_empty;
        logic emit_last;
        logic last_item;
    } sts_t;

endpackage

@@ hdl/lis_stream_if.sv @@
// ----------------------------------------------------------------------------
// LIS stream interface
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface lis_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ hdl/lis_ctrl.sv @@
// ----------------------------------------------------------------------------
// LIS controller
// Sequences search, table update, trace-back and emission.
// ----------------------------------------------------------------------------
module lis_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_load,
    input  logic          out_free,
    input  lis_pkg::sts_t sts,
    output lis_pkg::cmd_t cmd
);
    import lis_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SRCH;
                end
            end
            ST_SRCH:
            begin
                if (sts.full)
                begin
                    state_next = sts.last_item ? ST_TSTART : ST_IDLE;
                end
                else if (sts.srch_done)
                begin
                    state_next = ST_CHK;
                end
                else
                begin
                    state_next = ST_SWAIT;
                end
            end
            ST_SWAIT:  state_next = ST_SCMP;
            ST_SCMP:   state_next = ST_SRCH;
            ST_CHK:    state_next = ST_CWAIT;
            ST_CWAIT:  state_next = ST_UPD;
            ST_UPD:    state_next = sts.last_item ? ST_TSTART : ST_IDLE;
            ST_TSTART: state_next = sts.trace_empty ? ST_IDLE : ST_TWAIT;
            ST_TWAIT:  state_next = ST_TSTEP;
            ST_TSTEP:  state_next = sts.trace_done ? ST_EMIT : ST_TWAIT;
            ST_EMIT:   state_next = ST_EWAIT;
            ST_EWAIT:  state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = sts.emit_last ? ST_IDLE : ST_EWAIT;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.store_in = in_valid;
            end
            ST_SRCH:
            begin
                cmd.srch_rd   = !sts.full && !sts.srch_done;
                cmd.seq_clr   = 1'b0;
                cmd.trace_init = sts.full && sts.last_item;
            end
            ST_SWAIT:  cmd.srch_rd  = 1'b0;
            ST_SCMP:   cmd.srch_cmp = 1'b1;
            ST_CHK:    cmd.chk_rd   = 1'b1;
            ST_CWAIT:  cmd.chk_rd   = 1'b0;
            ST_UPD:
            begin
                cmd.upd        = 1'b1;
                cmd.trace_init = sts.last_item;
            end
            ST_TSTART:
            begin
                cmd.trace_rd = !sts.trace_empty;
                cmd.seq_clr  = sts.trace_empty;
            end
            ST_TWAIT:  cmd.trace_rd = 1'b0;
            ST_TSTEP:
            begin
                cmd.trace_step = 1'b1;
                cmd.trace_rd   = !sts.trace_done;
                cmd.emit_init  = sts.trace_done;
            end
            ST_EMIT:   cmd.emit_rd = 1'b1;
            ST_EWAIT:  cmd.emit_rd = 1'b0;
            ST_OUT:
            begin
                out_load      = out_free;
                cmd.emit_load = out_free;
                cmd.emit_adv  = out_free;
                cmd.emit_rd   = out_free && !sts.emit_last;
                cmd.seq_clr   = out_free && sts.emit_last;
            end
            default: cmd = '0;
        endcase
    end

`ifndef ASSERT_OFF
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == ST_IDLE)
        else $error("input taken outside idle");
    a_accept_search: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg == ST_SRCH)
        else $error("accepted transaction did not start search");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> out_free)
        else $error("result loaded into busy output");
`endif
endmodule

@@ hdl/lis_dp.sv @@
// ----------------------------------------------------------------------------
// LIS datapath
// Value, tail, predecessor and trace memories with search and trace logic.
// ----------------------------------------------------------------------------
module lis_dp
(
    input  logic               clk,
    input  logic               rst_n,
    input  lis_pkg::in_item_t  in_item,
    input  lis_pkg::cmd_t      cmd,
    output lis_pkg::sts_t      sts,
    output lis_pkg::out_item_t out_item
);
    import lis_pkg::*;

    sample_t vals_mem [MAX_ITEMS];
    sample_t tval_mem [MAX_ITEMS];
    idx_t    tpos_mem [MAX_ITEMS];
    cnt_t    pred_mem [MAX_ITEMS];
    sample_t trc_mem  [MAX_ITEMS];

    sample_t v_reg;
    logic    last_reg;
    cnt_t    best_reg, best_next;
    cnt_t    cnt_reg, cnt_next;
    logic    ovf_reg, ovf_next;
    cnt_t    lo_reg, lo_next, hi_reg, hi_next;
    cnt_t    k_reg, k_next;
    cnt_t    pos_reg, pos_next;
    cnt_t    n_reg, n_next;
    sample_t tv_rd_reg;
    idx_t    tp_rd_reg;
    sample_t val_rd_reg;
    cnt_t    pred_rd_reg;
    sample_t trc_rd_reg;
    logic    skip_reg;

    cnt_t mid;
    idx_t tr_addr;
    idx_t tw_addr;
    idx_t pos_idx;
    logic upd_en;

    assign mid     = cnt_t'((lo_reg + hi_reg) >> 1);
    assign pos_idx = cnt_reg[IDX_W-1:0];
    assign tr_addr = cmd.chk_rd ? idx_t'(lo_reg - 1'b1) :
                     cmd.trace_init ? idx_t'(n_next - 1'b1) : mid[IDX_W-1:0];
    assign tw_addr = lo_reg[IDX_W-1:0];
    assign upd_en  = cmd.upd && !skip_reg && (lo_reg < cnt_t'(MAX_ITEMS));

    always_ff @(posedge clk)
    begin
        if (cmd.store_in)
        begin
            v_reg    <= in_item.sample;
            last_reg <= in_item.final_item;
        end
        if (cmd.srch_rd || cmd.chk_rd || cmd.trace_init)
        begin
            tv_rd_reg <= tval_mem[tr_addr];
            tp_rd_reg <= (upd_en && tw_addr == tr_addr) ? pos_idx : tpos_mem[tr_addr];
        end
        if (cmd.upd && !sts.full)
        begin
            vals_mem[pos_idx] <= v_reg;
        end
        if (cmd.upd && skip_reg)
        begin
            pred_mem[pos_idx] <= cnt_t'(MAX_ITEMS);
        end
        if (upd_en)
        begin
            tval_mem[tw_addr] <= v_reg;
            tpos_mem[tw_addr] <= pos_idx;
            pred_mem[pos_idx] <= (lo_reg != '0) ? cnt_t'(tp_rd_reg) : cnt_t'(MAX_ITEMS);
        end
        if (cmd.trace_rd)
        begin
            val_rd_reg  <= vals_mem[pos_next[IDX_W-1:0]];
            pred_rd_reg <= pred_mem[pos_next[IDX_W-1:0]];
        end
        if (cmd.trace_step)
        begin
            trc_mem[idx_t'(k_reg - 1'b1)] <= pos_reg[IDX_W] ? '0 : val_rd_reg;
        end
        if (cmd.emit_rd)
        begin
            trc_rd_reg <= trc_mem[k_next[IDX_W-1:0]];
        end
        if (cmd.emit_load)
        begin
            out_item.element <= trc_rd_reg;
            out_item.run_end <= (k_reg + 1'b1) == n_reg;
            out_item.dropped <= ovf_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '0;
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
            lo_reg   <= '0;
            hi_reg   <= '0;
            k_reg    <= '0;
            pos_reg  <= '0;
            n_reg    <= '0;
            skip_reg <= 1'b0;
        end
        else
        begin
            best_reg <= best_next;
            cnt_reg  <= cnt_next;
            ovf_reg  <= ovf_next;
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            k_reg    <= k_next;
            pos_reg  <= pos_next;
            n_reg    <= n_next;
            if (cmd.chk_rd)
            begin
                skip_reg <= 1'b0;
            end
            else if (cmd.upd)
            begin
                skip_reg <= 1'b0;
            end
            else if (lo_reg != '0 && tv_rd_reg == v_reg)
            begin
                skip_reg <= 1'b1;
            end
        end
    end

    always_comb
    begin
        best_next = best_reg;
        cnt_next  = cnt_reg;
        ovf_next  = ovf_reg;
        lo_next   = lo_reg;
        hi_next   = hi_reg;
        k_next    = k_reg;
        pos_next  = pos_reg;
        n_next    = n_reg;
        if (cmd.store_in)
        begin
            lo_next = '0;
            hi_next = best_reg;
            if (cnt_reg >= cnt_t'(MAX_ITEMS))
            begin
                ovf_next = 1'b1;
            end
        end
        if (cmd.srch_cmp)
        begin
            if ($signed(tv_rd_reg) > $signed(v_reg))
            begin
                hi_next = mid;
            end
            else
            begin
                lo_next = cnt_t'(mid + 1'b1);
            end
        end
        if (cmd.upd)
        begin
            cnt_next = cnt_t'(cnt_reg + 1'b1);
            if (upd_en && lo_reg == best_reg)
            begin
                best_next = cnt_t'(best_reg + 1'b1);
            end
        end
        if (cmd.trace_init)
        begin
            n_next = (cmd.upd && upd_en && lo_reg == best_reg) ?
                     cnt_t'(best_reg + 1'b1) : best_reg;
            k_next = n_next;
        end
        if (cmd.trace_rd && !cmd.trace_step)
        begin
            pos_next = cnt_t'(tp_rd_reg);
        end
        if (cmd.trace_step)
        begin
            k_next   = cnt_t'(k_reg - 1'b1);
            pos_next = pos_reg[IDX_W] ? pos_reg : pred_rd_reg;
        end
        if (cmd.emit_init)
        begin
            k_next = '0;
        end
        if (cmd.emit_adv)
        begin
            k_next = cnt_t'(k_reg + 1'b1);
        end
        if (cmd.seq_clr)
        begin
            best_next = '0;
            cnt_next  = '0;
            ovf_next  = 1'b0;
        end
    end

    assign sts.full        = cnt_reg >= cnt_t'(MAX_ITEMS);
    assign sts.srch_done   = lo_reg >= hi_reg;
    assign sts.trace_done  = k_reg == cnt_t'(1);
    assign sts.trace_empty = n_reg == '0;
    assign sts.emit_last   = (k_reg + 1'b1) == n_reg;
    assign sts.last_item   = last_reg;

`ifndef ASSERT_OFF
    a_best_cap: assert property (@(posedge clk) disable iff (!rst_n)
        best_reg <= cnt_reg)
        else $error("more tails than items");
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= cnt_t'(MAX_ITEMS))
        else $error("item count beyond capacity");
    a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.srch_cmp |-> lo_reg < hi_reg)
        else $error("search step on empty range");
`endif
endmodule

@@ hdl/longest_increasing_subsequence_core.sv @@
// Each binary-search step reads the tail table, waits, then compares; an item that finds the table full is dropped.
// Final item: trace-back walks the predecessor links per element, then each element is sent out.
// One item at a time; the single-port table read bounds each search step.
// Reset (rst_n, asynchronous) clears sequence counters; memories are not reset
// and hold garbage until written.
// ----------------------------------------------------------------------------
// Longest increasing subsequence core
// Patience search over a tail table with trace-back of the longest run.
// ----------------------------------------------------------------------------
module longest_increasing_subsequence_core
(
    input  logic        clk,
    input  logic        rst_n,
    lis_stream_if.sink   in_ch,
    lis_stream_if.source out_ch
);
    import lis_pkg::*;

    cmd_t      cmd;
    sts_t      sts;
    out_item_t out_item;
    logic      out_valid_reg;
    logic      out_load;
    logic      out_free;

    assign out_free = !out_valid_reg || out_ch.ready;

    lis_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .out_load (out_load),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd)
    );

    lis_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_ch.payload),
        .cmd      (cmd),
        .sts      (sts),
        .out_item (out_item)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_item;
endmodule
